// ===== hw/rtl/rlw_pkg.sv =====
// Shared types, codes and reset values for the radio liveness watchdog.
`timescale 1ns / 1ps

package rlw_pkg;

	// Default width of the internal time arithmetic.
	localparam int TIME_BITS_DEF = 32;

	// Widths of the fields and registers.
	localparam int FIELD_W = 32;
	localparam int MS_W    = 31;
	localparam int PHASE_W = 2;
	localparam int INDEX_W = 8;

	typedef logic [PHASE_W-1:0] phase_t;

	// Watchdog phase codes.
	localparam phase_t PH_IDLE     = 2'd0;
	localparam phase_t PH_TESTING  = 2'd1;
	localparam phase_t PH_REINITED = 2'd2;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_ARMED          = 8'd0;
	localparam logic [INDEX_W-1:0] REG_IDLE_TIME      = 8'd1;
	localparam logic [INDEX_W-1:0] REG_CHECK_INTERVAL = 8'd2;
	localparam logic [INDEX_W-1:0] REG_GRACE_TIME     = 8'd3;

	// Register reset values.
	localparam logic [MS_W-1:0] CHECK_INTERVAL_RST = 31'd1000;
	localparam logic [MS_W-1:0] GRACE_TIME_RST     = 31'd10000;

endpackage

// ===== hw/rtl/radio_liveness_watchdog.sv =====
// Top level of the radio liveness watchdog: poll input, state update and result output.
`timescale 1ns / 1ps

// The host sends one poll per transfer on the in channel (time, airtime counter and the
// counter read after a reinit) and receives exactly one result per poll on the out
// channel: whether the poll was evaluated, the probe, reinit and reboot requests, the
// phase after the poll and the running reinit count.
// The cfg channel writes the armed flag, idle time, check interval and grace time by
// register index; an index beyond the list is ignored. cfg_ready is always high, and
// registers are meant to be written while no poll is in flight.
// A poll accepted into the input register has the state update and result computed from
// it combinationally, and the result is then held in the result register, which drives
// the out channel. Throughput is one poll per cycle while the receiver takes results, set by
// the single compare-and-update pass between the input register and the result register.
// Reset clears the watchdog state and loads the register defaults (disarmed, interval
// 1000 ms, grace 10000 ms). When the receiver stalls, the result register holds, the
// input register fills, and in_ready falls once both hold a poll while out_ready is low.
module radio_liveness_watchdog #(
	parameter int TIME_BITS = rlw_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rlw_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [rlw_pkg::FIELD_W-1:0]  cfg_data,
	// Poll channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rlw_pkg::FIELD_W-1:0]  now_ms,
	input  logic [rlw_pkg::FIELD_W-1:0]  airtime_now,
	input  logic [rlw_pkg::FIELD_W-1:0]  airtime_after_reinit,
	// Result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         checked,
	output logic                         probe_request,
	output logic                         reinit_request,
	output logic                         reboot_request,
	output logic [rlw_pkg::PHASE_W-1:0]  watchdog_state,
	output logic [rlw_pkg::FIELD_W-1:0]  reinit_total
);
	import rlw_pkg::*;

	localparam int EXT_W = TIME_BITS + FIELD_W;

	// Configuration registers.
	logic            armed_q;
	logic [MS_W-1:0] idle_time_q;
	logic [MS_W-1:0] check_interval_q;
	logic [MS_W-1:0] grace_time_q;

	// Watchdog state.
	logic [TIME_BITS-1:0] next_check_q, next_check_d;
	logic                 check_valid_q, check_valid_d;
	logic [FIELD_W-1:0]   last_air_q, last_air_d;
	logic [TIME_BITS-1:0] activity_time_q, activity_time_d;
	logic                 activity_valid_q, activity_valid_d;
	logic [FIELD_W-1:0]   test_air_q, test_air_d;
	logic [TIME_BITS-1:0] test_start_q, test_start_d;
	phase_t               phase_q, phase_d;
	logic [FIELD_W-1:0]   reinit_cnt_q, reinit_cnt_d;

	// Input register.
	logic               valid_s1;
	logic [FIELD_W-1:0] now_s1;
	logic [FIELD_W-1:0] air_s1;
	logic [FIELD_W-1:0] air_reinit_s1;

	// Result register.
	logic               valid_s2;
	logic               checked_s2;
	logic               probe_s2;
	logic               reinit_s2;
	logic               reboot_s2;
	phase_t             phase_s2;
	logic [FIELD_W-1:0] reinit_total_s2;

	// Combinational results of one poll.
	logic                 advance;
	logic [EXT_W-1:0]     now_ext;
	logic [TIME_BITS-1:0] now_t;
	logic [EXT_W-1:0]     interval_ext;
	logic [TIME_BITS-1:0] check_diff;
	logic [TIME_BITS-1:0] idle_diff;
	logic [TIME_BITS-1:0] grace_diff;
	logic                 skip;
	logic                 idle_elapsed;
	logic                 grace_elapsed;
	logic                 checked_d;
	logic                 probe_d;
	logic                 reinit_d;
	logic                 reboot_d;

	// Handshakes: the result register frees when taken, the input register moves on then.
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Time arithmetic modulo 2^TIME_BITS.
	assign now_ext      = {{TIME_BITS{1'b0}}, now_s1};
	assign now_t        = now_ext[TIME_BITS-1:0];
	assign interval_ext = {{(EXT_W-MS_W){1'b0}}, check_interval_q};
	assign check_diff   = now_t - next_check_q;
	assign idle_diff    = now_t - activity_time_q;
	assign grace_diff   = now_t - test_start_q;
	assign skip         = check_valid_q && check_diff[TIME_BITS-1];

	// A span counts as elapsed when it is non-negative and at least the limit.
	assign idle_elapsed = !idle_diff[TIME_BITS-1]
		&& ({{FIELD_W{1'b0}}, idle_diff} >= {{(EXT_W-MS_W){1'b0}}, idle_time_q});
	assign grace_elapsed = !grace_diff[TIME_BITS-1]
		&& ({{FIELD_W{1'b0}}, grace_diff} >= {{(EXT_W-MS_W){1'b0}}, grace_time_q});

	// Evaluate one poll against the current state.
	always_comb begin
		next_check_d     = next_check_q;
		check_valid_d    = check_valid_q;
		last_air_d       = last_air_q;
		activity_time_d  = activity_time_q;
		activity_valid_d = activity_valid_q;
		test_air_d       = test_air_q;
		test_start_d     = test_start_q;
		phase_d          = phase_q;
		reinit_cnt_d     = reinit_cnt_q;
		checked_d        = 1'b0;
		probe_d          = 1'b0;
		reinit_d         = 1'b0;
		reboot_d         = 1'b0;
		if (armed_q && !skip) begin
			checked_d     = 1'b1;
			next_check_d  = now_t + interval_ext[TIME_BITS-1:0];
			check_valid_d = 1'b1;
			if (air_s1 != last_air_q) begin
				// Any airtime change is activity.
				last_air_d       = air_s1;
				activity_time_d  = now_t;
				activity_valid_d = 1'b1;
				phase_d          = PH_IDLE;
			end else if (!activity_valid_q) begin
				activity_time_d  = now_t;
				activity_valid_d = 1'b1;
			end else begin
				case (phase_q)
					PH_IDLE: begin
						if (idle_elapsed) begin
							test_air_d   = air_s1;
							test_start_d = now_t;
							phase_d      = PH_TESTING;
							probe_d      = 1'b1;
						end
					end
					PH_TESTING, PH_REINITED: begin
						if (grace_elapsed) begin
							if (air_s1 != test_air_q) begin
								last_air_d      = air_s1;
								activity_time_d = now_t;
								phase_d         = PH_IDLE;
							end else if (phase_q == PH_TESTING) begin
								reinit_cnt_d = reinit_cnt_q + FIELD_W'(1);
								reinit_d     = 1'b1;
								test_start_d = now_t;
								test_air_d   = air_reinit_s1;
								phase_d      = PH_REINITED;
								probe_d      = 1'b1;
							end else begin
								reboot_d = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q          <= 1'b0;
			idle_time_q      <= '0;
			check_interval_q <= CHECK_INTERVAL_RST;
			grace_time_q     <= GRACE_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ARMED:          armed_q          <= cfg_data[0];
				REG_IDLE_TIME:      idle_time_q      <= cfg_data[MS_W-1:0];
				REG_CHECK_INTERVAL: check_interval_q <= cfg_data[MS_W-1:0];
				REG_GRACE_TIME:     grace_time_q     <= cfg_data[MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Watchdog state, updated when a poll leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_check_q     <= '0;
			check_valid_q    <= 1'b0;
			last_air_q       <= '0;
			activity_time_q  <= '0;
			activity_valid_q <= 1'b0;
			test_air_q       <= '0;
			test_start_q     <= '0;
			phase_q          <= PH_IDLE;
			reinit_cnt_q     <= '0;
		end else if (valid_s1 && advance) begin
			next_check_q     <= next_check_d;
			check_valid_q    <= check_valid_d;
			last_air_q       <= last_air_d;
			activity_time_q  <= activity_time_d;
			activity_valid_q <= activity_valid_d;
			test_air_q       <= test_air_d;
			test_start_q     <= test_start_d;
			phase_q          <= phase_d;
			reinit_cnt_q     <= reinit_cnt_d;
		end
	end

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1        <= now_ms;
			air_s1        <= airtime_now;
			air_reinit_s1 <= airtime_after_reinit;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			checked_s2      <= checked_d;
			probe_s2        <= probe_d;
			reinit_s2       <= reinit_d;
			reboot_s2       <= reboot_d;
			phase_s2        <= phase_d;
			reinit_total_s2 <= reinit_cnt_d;
		end
	end

	assign out_valid      = valid_s2;
	assign checked        = checked_s2;
	assign probe_request  = probe_s2;
	assign reinit_request = reinit_s2;
	assign reboot_request = reboot_s2;
	assign watchdog_state = phase_s2;
	assign reinit_total   = reinit_total_s2;

endmodule

// ===== hw/rtl/rlw_checker.sv =====
// Port-level assertions for the radio liveness watchdog and the bind that attaches them.
`timescale 1ns / 1ps

module rlw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         checked,
	input logic                         probe_request,
	input logic                         reinit_request,
	input logic                         reboot_request,
	input logic [rlw_pkg::PHASE_W-1:0]  watchdog_state,
	input logic [rlw_pkg::FIELD_W-1:0]  reinit_total
);
	import rlw_pkg::*;

	// A stalled result holds its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reinit_total)
			&& $stable(watchdog_state) && $stable(checked))
		else $error("result changed while stalled");

	// A skipped poll never raises a request.
	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !checked |-> !probe_request && !reinit_request && !reboot_request)
		else $error("request on a skipped poll");

	// A reinit comes with a probe and leaves the block in the reinited phase.
	a_reinit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reinit_request |-> probe_request && !reboot_request
			&& watchdog_state == PH_REINITED)
		else $error("reinit without probe or wrong phase");

	// A reboot is asked only from the reinited phase and without a probe.
	a_reboot_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reboot_request |-> !probe_request && watchdog_state == PH_REINITED)
		else $error("reboot outside the reinited phase");

	// The reinit count moves only on a result that requests a reinit.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && !reinit_request
			|-> reinit_total == $past(reinit_total))
		else $error("reinit count changed without a reinit");

endmodule

bind radio_liveness_watchdog rlw_checker u_rlw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.checked        (checked),
	.probe_request  (probe_request),
	.reinit_request (reinit_request),
	.reboot_request (reboot_request),
	.watchdog_state (watchdog_state),
	.reinit_total   (reinit_total)
);

// ===== tb/tb_top.sv =====
// Testbench for the radio liveness watchdog: directed and random polls checked against a behavioral prediction.
`timescale 1ns / 1ps

module tb_top;
	import rlw_pkg::*;

	localparam int  HOLD_CYCLES   = 150;
	localparam int  SEGMENT_POLLS = 50;
	localparam int  SETTLE_CYCLES = 4;
	localparam time TIMEOUT_NS    = 2_000_000;

	// One expected result transfer.
	typedef struct packed {
		logic        checked;
		logic        probe;
		logic        reinit;
		logic        reboot;
		phase_t      state;
		logic [31:0] total;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [INDEX_W-1:0] cfg_index = '0;
	logic [FIELD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FIELD_W-1:0] now_ms = '0;
	logic [FIELD_W-1:0] airtime_now = '0;
	logic [FIELD_W-1:0] airtime_after_reinit = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic checked;
	logic probe_request;
	logic reinit_request;
	logic reboot_request;
	logic [PHASE_W-1:0] watchdog_state;
	logic [FIELD_W-1:0] reinit_total;

	// Predicted watchdog registers and state, starting at their reset values.
	logic        arm_en = 1'b0;
	logic [30:0] idle_ms = '0;
	logic [30:0] interval_ms = CHECK_INTERVAL_RST;
	logic [30:0] grace_ms = GRACE_TIME_RST;
	logic [31:0] due_ms = '0;
	logic        due_known = 1'b0;
	logic [31:0] seen_air = '0;
	logic [31:0] active_ms = '0;
	logic        active_known = 1'b0;
	logic [31:0] probe_air = '0;
	logic [31:0] probe_ms = '0;
	phase_t      wd_phase = PH_IDLE;
	logic [31:0] reinit_count = '0;

	verdict_t pending_verdicts[$];
	int fail_count = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic recv_hold = 1'b0;
	event hold_ev;

	logic [31:0] cur_ms = '0;
	logic [31:0] cur_air = '0;

	radio_liveness_watchdog dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.now_ms               (now_ms),
		.airtime_now          (airtime_now),
		.airtime_after_reinit (airtime_after_reinit),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.checked              (checked),
		.probe_request        (probe_request),
		.reinit_request       (reinit_request),
		.reboot_request       (reboot_request),
		.watchdog_state       (watchdog_state),
		.reinit_total         (reinit_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// True when the wrapped, signed span from start to now has reached limit.
	function automatic logic span_reached(logic [31:0] now, logic [31:0] start,
			logic [30:0] limit);
		logic [31:0] span;
		span = now - start;
		return !span[31] && span >= {1'b0, limit};
	endfunction

	// Advances the predicted watchdog by one poll and returns the result it owes.
	function automatic verdict_t judge_poll(logic [31:0] now, logic [31:0] air,
			logic [31:0] air_ri);
		verdict_t v;
		logic [31:0] lag;
		v = '0;
		lag = now - due_ms;
		if (arm_en && (!due_known || !lag[31])) begin
			v.checked = 1'b1;
			due_ms = now + {1'b0, interval_ms};
			due_known = 1'b1;
			if (air != seen_air) begin
				seen_air = air;
				active_ms = now;
				active_known = 1'b1;
				wd_phase = PH_IDLE;
			end else if (!active_known) begin
				active_ms = now;
				active_known = 1'b1;
			end else if (wd_phase == PH_IDLE) begin
				if (span_reached(now, active_ms, idle_ms)) begin
					probe_air = air;
					probe_ms = now;
					wd_phase = PH_TESTING;
					v.probe = 1'b1;
				end
			end else if (wd_phase == PH_TESTING || wd_phase == PH_REINITED) begin
				if (span_reached(now, probe_ms, grace_ms)) begin
					if (air != probe_air) begin
						// The radio answered the probe: back to idle.
						seen_air = air;
						active_ms = now;
						wd_phase = PH_IDLE;
					end else if (wd_phase == PH_TESTING) begin
						reinit_count = reinit_count + 1;
						v.reinit = 1'b1;
						v.probe = 1'b1;
						probe_ms = now;
						probe_air = air_ri;
						wd_phase = PH_REINITED;
					end else begin
						v.reboot = 1'b1;
					end
				end
			end
		end
		v.state = wd_phase;
		v.total = reinit_count;
		return v;
	endfunction

	// Track register writes and polls, and check every result transfer in order.
	always @(posedge clk) begin : scoreboard
		verdict_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("result transfer with no poll outstanding");
					fail_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (checked !== want.checked) begin
						$error("checked: expected %0d, got %0d", want.checked, checked);
						fail_count++;
					end
					if (probe_request !== want.probe) begin
						$error("probe_request: expected %0d, got %0d", want.probe,
							probe_request);
						fail_count++;
					end
					if (reinit_request !== want.reinit) begin
						$error("reinit_request: expected %0d, got %0d", want.reinit,
							reinit_request);
						fail_count++;
					end
					if (reboot_request !== want.reboot) begin
						$error("reboot_request: expected %0d, got %0d", want.reboot,
							reboot_request);
						fail_count++;
					end
					if (watchdog_state !== want.state) begin
						$error("watchdog_state: expected %0d, got %0d", want.state,
							watchdog_state);
						fail_count++;
					end
					if (reinit_total !== want.total) begin
						$error("reinit_total: expected %0d, got %0d", want.total,
							reinit_total);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ARMED:          arm_en = cfg_data[0];
					REG_IDLE_TIME:      idle_ms = cfg_data[30:0];
					REG_CHECK_INTERVAL: interval_ms = cfg_data[30:0];
					REG_GRACE_TIME:     grace_ms = cfg_data[30:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_verdicts.push_back(judge_poll(now_ms, airtime_now,
					airtime_after_reinit));
		end
	end

	// Receiver: random stalls, or a long hold while recv_hold is set.
	always @(negedge clk) begin
		if (recv_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Long receiver hold, counted here once triggered.
	always begin : receiver_hold
		@(hold_ev);
		recv_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_hold <= 1'b0;
	end

	// Offers one poll, with a random gap first, and returns after its transfer.
	task automatic send_poll(input logic [31:0] t, input logic [31:0] air,
			input logic [31:0] air_ri);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		airtime_now <= air;
		airtime_after_reinit <= air_ri;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes one register; the caller lowers cfg_valid after its last write.
	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input logic arm, input logic [30:0] idle,
			input logic [30:0] interval, input logic [30:0] grace);
		write_reg(REG_ARMED, {31'd0, arm});
		write_reg(REG_IDLE_TIME, {1'b0, idle});
		write_reg(REG_CHECK_INTERVAL, {1'b0, interval});
		write_reg(REG_GRACE_TIME, {1'b0, grace});
		cfg_valid <= 1'b0;
	endtask

	// Stops offering polls and waits until every result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(negedge clk);
	endtask

	// Mostly small values, sometimes zero or the largest value.
	function automatic logic [30:0] rand_ms();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return 31'($urandom_range(0, 2000));
	endfunction

	// Random register set; the unused top bit of each write is random too.
	task automatic pick_random_setup();
		logic [31:0] word;
		word = $urandom;
		word[0] = ($urandom_range(0, 9) != 0);
		write_reg(REG_ARMED, word);
		write_reg(REG_IDLE_TIME, {1'($urandom_range(0, 1)), rand_ms()});
		write_reg(REG_CHECK_INTERVAL, {1'($urandom_range(0, 1)), rand_ms()});
		write_reg(REG_GRACE_TIME, {1'($urandom_range(0, 1)), rand_ms()});
		cfg_valid <= 1'b0;
	endtask

	// Time mostly moves forward in small steps; sometimes it jumps or runs back.
	task automatic random_poll();
		int unsigned pick;
		logic [31:0] air_ri;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			cur_ms += $urandom_range(0, 1500);
		else if (pick < 90)
			cur_ms += $urandom;
		else
			cur_ms -= $urandom_range(0, 3000);
		if ($urandom_range(0, 99) < 8)
			cur_air = ($urandom_range(0, 1) != 0) ? $urandom : cur_air + 1;
		air_ri = ($urandom_range(0, 1) != 0) ? cur_air : $urandom;
		send_poll(cur_ms, cur_air, air_ri);
	endtask

	// Reset defaults leave the watchdog disarmed: polls do nothing.
	task automatic test_disarmed();
		drain();
		send_poll(32'd0, 32'd0, 32'd0);
		send_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_poll(32'd12345, 32'd1, 32'd2);
	endtask

	// Full escalation: first sighting, probe, reinit, reboot, recovery.
	task automatic test_escalation();
		drain();
		configure(1'b1, 31'd100, 31'd0, 31'd50);
		send_poll(32'd0, 32'd0, 32'd0);
		send_poll(32'd60, 32'd0, 32'd0);
		send_poll(32'd100, 32'd0, 32'd0);
		send_poll(32'd140, 32'd0, 32'd0);
		send_poll(32'd150, 32'd0, 32'd0);
		send_poll(32'd200, 32'd0, 32'd0);
		send_poll(32'd260, 32'd0, 32'd0);
		send_poll(32'd270, 32'd5, 32'd0);
		send_poll(32'd370, 32'd5, 32'd0);
		// Counter after the reinit differs, so the next check sees recovery.
		send_poll(32'd420, 32'd5, 32'd9);
		send_poll(32'd470, 32'd5, 32'd5);
	endtask

	// Skipped polls and poll times that wrap past the top of the clock.
	task automatic test_check_interval();
		drain();
		configure(1'b1, 31'd0, 31'd1000, 31'h7FFF_FFFF);
		send_poll(32'hFFFF_FE00, 32'd5, 32'd5);
		send_poll(32'hFFFF_FF00, 32'd5, 32'd5);
		send_poll(32'h0000_01E7, 32'd5, 32'd5);
		send_poll(32'h0000_01E8, 32'd5, 32'd5);
	endtask

	// Largest idle time, zero grace, and a time behind the test start.
	task automatic test_time_behind();
		drain();
		configure(1'b1, 31'h7FFF_FFFF, 31'd0, 31'd0);
		send_poll(32'h0000_1000, 32'd7, 32'd7);
		send_poll(32'h8000_0FFE, 32'd7, 32'd7);
		send_poll(32'h8000_0FFF, 32'd7, 32'd7);
		send_poll(32'h8000_0FFE, 32'd7, 32'd7);
		send_poll(32'h8000_0FFF, 32'd7, 32'd7);
		send_poll(32'h0000_0000, 32'd7, 32'd7);
	endtask

	// Writes to unused indexes are dropped; values are cut to register width.
	task automatic test_register_writes();
		drain();
		write_reg(8'd4, $urandom);
		write_reg(8'hFF, 32'hFFFF_FFFF);
		write_reg(8'h80, $urandom);
		write_reg(REG_IDLE_TIME, 32'hFFFF_FFFF);
		write_reg(REG_GRACE_TIME, 32'h8000_0000);
		write_reg(REG_ARMED, 32'hFFFF_FFFE);
		cfg_valid <= 1'b0;
		send_poll(32'd500, 32'd3, 32'd3);
		drain();
		write_reg(REG_ARMED, 32'hFFFF_FFFF);
		write_reg(REG_CHECK_INTERVAL, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_poll(32'd600, 32'd3, 32'd3);
		send_poll(32'd700, 32'd3, 32'd3);
	endtask

	// Random register sets, each followed by a run of random polls.
	task automatic test_random(input int segments);
		repeat (segments) begin
			drain();
			pick_random_setup();
			repeat (SEGMENT_POLLS) random_poll();
		end
	endtask

	// Receiver holds off while polls keep coming, so the input must stall.
	task automatic test_backpressure();
		drain();
		configure(1'b1, 31'd300, 31'd0, 31'd200);
		-> hold_ev;
		repeat (40) random_poll();
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		cur_ms = $urandom;
		test_disarmed();
		test_escalation();
		test_check_interval();
		test_time_behind();
		test_register_writes();
		cur_air = $urandom;
		drain();
		set_idling(17, 83);
		test_random(4);
		drain();
		set_idling(83, 17);
		test_random(4);
		drain();
		set_idling(0, 0);
		test_backpressure();
		test_random(4);
		drain();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== radio_liveness_watchdog.f =====
hw/rtl/rlw_pkg.sv
hw/rtl/radio_liveness_watchdog.sv
hw/rtl/rlw_checker.sv
tb/tb_top.sv
